// File: src/wkpq_pkg.sv
// Package: entry, link and command types, codes and the key function for the queue.
`default_nettype none
package wkpq_pkg;

   localparam int DEF_CAPACITY = 16;

   localparam int TAG_W    = 8;
   localparam int FARE_W   = 16;
   localparam int POINT_W  = 10;
   localparam int KEY_W    = 17;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [FARE_W-1:0]  fare;
      logic [POINT_W-1:0] point;
      logic [KEY_W-1:0]   key;
   } entry_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic      valid;
      logic      keep;
      entry_type entry;
   } link_type;

   // broadcast to every cell
   typedef struct packed {
      logic      ins;
      logic      del;
      entry_type entry;
   } cmd_type;

   // key = fare + 50*point + 50, in hundredths
   function automatic logic [KEY_W-1:0] weighted_key(input logic [FARE_W-1:0] fare,
                                                     input logic [POINT_W-1:0] point);
      logic [KEY_W-1:0] p;
      p = {{(KEY_W-POINT_W){1'b0}}, point};
      return {{(KEY_W-FARE_W){1'b0}}, fare} + (p << 5) + (p << 4) + (p << 1)
             + KEY_W'(50);
   endfunction

endpackage
`default_nettype wire

// File: src/weighted_key_priority_queue_core.sv
// Top level: sorted priority queue built as a chain of shifting cells.
//
//  channel  | ports                                        | handshake
//  request  | req_operation, req_tag, req_fare, req_point  | start & !busy
//  response | rsp_status, rsp_out_tag, rsp_out_fare,      | rsp_strobe, one cycle
//           | rsp_out_point, rsp_occupancy                 |
//
// One request per cycle; busy stays low. The response is registered and
// appears in the cycle after the request.
// Insert places the entry by a parallel compare in every cell.
// Reset clears the count, the response strobe and the cell valid bits; entries hold no reset.
// The receiver cannot stall: each response shows for exactly one cycle.
`default_nettype none
module weighted_key_priority_queue_core
   import wkpq_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_operation,
   input  wire logic [TAG_W-1:0]   req_tag,
   input  wire logic [FARE_W-1:0]  req_fare,
   input  wire logic [POINT_W-1:0] req_point,
   output logic                    rsp_strobe,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [TAG_W-1:0]        rsp_out_tag,
   output logic [FARE_W-1:0]       rsp_out_fare,
   output logic [POINT_W-1:0]      rsp_out_point,
   output logic [OCC_W-1:0]        rsp_occupancy
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept, full, empty;
   cmd_type          cmd;
   link_type         lnk [CAPACITY];
   link_type         head_bound, tail_bound;

   logic                rsp_strobe_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [FARE_W-1:0]   fare_ff, fare_in;
   logic [POINT_W-1:0]  point_ff, point_in;
   logic [OCC_W-1:0]    occ_ff;
   logic [CNT_W+OCC_W-1:0] count_ext;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);

   assign cmd.ins         = accept && (req_operation == OP_INSERT) && !full;
   assign cmd.del         = accept && (req_operation == OP_REMOVE) && !empty;
   assign cmd.entry.tag   = req_tag;
   assign cmd.entry.fare  = req_fare;
   assign cmd.entry.point = req_point;
   assign cmd.entry.key   = weighted_key(req_fare, req_point);

   assign head_bound.valid = 1'b1;
   assign head_bound.keep  = 1'b1;
   assign head_bound.entry = '0;
   assign tail_bound.valid = 1'b0;
   assign tail_bound.keep  = 1'b0;
   assign tail_bound.entry = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      link_type left_l, right_l;
      if (i == 0) begin : g_head
         assign left_l = head_bound;
      end else begin : g_mid_l
         assign left_l = lnk[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_l = tail_bound;
      end else begin : g_mid_r
         assign right_l = lnk[i+1];
      end
      wkpq_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .left  (left_l),
         .right (right_l),
         .self  (lnk[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      tag_in    = '0;
      fare_in   = '0;
      point_in  = '0;
      if (req_operation == OP_INSERT) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            count_in = count_ff - CNT_W'(1);
            tag_in   = lnk[0].entry.tag;
            fare_in  = lnk[0].entry.fare;
            point_in = lnk[0].entry.point;
         end
      end
   end

   assign count_ext = {{OCC_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         tag_ff    <= tag_in;
         fare_ff   <= fare_in;
         point_ff  <= point_in;
         occ_ff    <= count_ext[OCC_W-1:0];
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_tag   = tag_ff;
   assign rsp_out_fare  = fare_ff;
   assign rsp_out_point = point_ff;
   assign rsp_occupancy = occ_ff;

endmodule
`default_nettype wire

// File: src/wkpq_cell.sv
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
`default_nettype none
module wkpq_cell
   import wkpq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cmd_type  cmd,
   input  wire link_type left,
   input  wire link_type right,
   output link_type      self
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      keep;

   assign keep = valid_ff && (entry_ff.key <= cmd.entry.key);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (keep) begin
            valid_in = valid_ff;
         end else if (left.keep) begin
            valid_in = 1'b1;
            entry_in = cmd.entry;
         end else begin
            valid_in = left.valid;
            entry_in = left.entry;
         end
      end else if (cmd.del) begin
         valid_in = right.valid;
         entry_in = right.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign self.valid = valid_ff;
   assign self.keep  = keep;
   assign self.entry = entry_ff;

endmodule
`default_nettype wire

// File: src/wkpq_checker.sv
// Port checker for the queue top level, with its bind.
`default_nettype none
module wkpq_checker
   import wkpq_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_strobe,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [TAG_W-1:0]    rsp_out_tag,
   input wire logic [FARE_W-1:0]   rsp_out_fare,
   input wire logic [POINT_W-1:0]  rsp_out_point,
   input wire logic [OCC_W-1:0]    rsp_occupancy
);

   localparam logic [OCC_W+8:0] CAP_W = (OCC_W+9)'(CAPACITY);

   a_one_rsp_per_request: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_strobe == $past(start && !busy)))
      else $error("response strobe does not follow request");

   a_err_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |->
         (rsp_out_tag == '0 && rsp_out_fare == '0 && rsp_out_point == '0))
      else $error("error response carries entry data");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty flag with nonzero occupancy");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> (rsp_occupancy == CAP_W[OCC_W-1:0]))
      else $error("full flag with occupancy not at capacity");

endmodule

bind weighted_key_priority_queue_core wkpq_checker #(.CAPACITY(CAPACITY)) u_wkpq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_status    (rsp_status),
   .rsp_out_tag   (rsp_out_tag),
   .rsp_out_fare  (rsp_out_fare),
   .rsp_out_point (rsp_out_point),
   .rsp_occupancy (rsp_occupancy)
);
`default_nettype wire

// File: bench/tb_weighted_key_priority_queue_core.sv
// Testbench for the weighted-key priority queue: directed and random requests vs. a predictor.
`timescale 1ns / 1ps

module tb_weighted_key_priority_queue_core;
   import wkpq_pkg::*;

   localparam int CAPACITY   = DEF_CAPACITY;
   localparam int RANDOM_REQ = 476;
   localparam int IDLE_LIMIT = 5000;
   localparam int SHOWN_MAX  = 10;

   typedef struct packed {
      logic               op;
      logic [TAG_W-1:0]   tag;
      logic [FARE_W-1:0]  fare;
      logic [POINT_W-1:0] point;
   } fare_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    tag;
      logic [FARE_W-1:0]   fare;
      logic [POINT_W-1:0]  point;
      logic [OCC_W-1:0]    occupancy;
   } queue_response_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic req_operation;
   logic [TAG_W-1:0] req_tag;
   logic [FARE_W-1:0] req_fare;
   logic [POINT_W-1:0] req_point;
   logic rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [TAG_W-1:0] rsp_out_tag;
   logic [FARE_W-1:0] rsp_out_fare;
   logic [POINT_W-1:0] rsp_out_point;
   logic [OCC_W-1:0] rsp_occupancy;

   fare_request_type   pending_requests[$];
   queue_response_type expected_responses[$];
   fare_request_type   held_entries[CAPACITY];
   int                 held_count = 0;
   int                 sent_count = 0;
   int                 mismatch_count = 0;
   int                 quiet_cycles = 0;

   weighted_key_priority_queue_core #(.CAPACITY(CAPACITY)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_tag(req_tag),
      .req_fare(req_fare),
      .req_point(req_point),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_out_tag(rsp_out_tag),
      .rsp_out_fare(rsp_out_fare),
      .rsp_out_point(rsp_out_point),
      .rsp_occupancy(rsp_occupancy)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int queue_key(input fare_request_type e);
      return int'(e.fare) + 50 * int'(e.point) + 50;
   endfunction

   function automatic queue_response_type predict_response(input fare_request_type r);
      queue_response_type rsp;
      int slot;
      int i;
      rsp = '0;
      rsp.status = ST_OK;
      if (r.op == OP_INSERT) begin
         if (held_count >= CAPACITY) begin
            rsp.status = ST_FULL;
         end else begin
            slot = 0;
            while (slot < held_count && queue_key(held_entries[slot]) <= queue_key(r))
               slot++;
            for (i = held_count; i > slot; i--)
               held_entries[i] = held_entries[i-1];
            held_entries[slot] = r;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            rsp.status = ST_EMPTY;
         end else begin
            rsp.tag = held_entries[0].tag;
            rsp.fare = held_entries[0].fare;
            rsp.point = held_entries[0].point;
            for (i = 1; i < held_count; i++)
               held_entries[i-1] = held_entries[i];
            held_count--;
         end
      end
      rsp.occupancy = OCC_W'(held_count);
      return rsp;
   endfunction

   task automatic add_request(input logic op, input int tag, input int fare, input int point);
      fare_request_type r;
      r.op = op;
      r.tag = TAG_W'(tag);
      r.fare = FARE_W'(fare);
      r.point = POINT_W'(point);
      pending_requests.push_back(r);
   endtask

   // entry contents: equal-key family, extremes, or anything
   task automatic add_random_request(input logic op);
      int mode;
      int point;
      int fare;
      mode = $urandom_range(9);
      if (mode < 2) begin
         point = $urandom_range(3);
         fare = 1000 - 50 * point;
      end else if (mode == 2) begin
         point = $urandom_range(1) ? 1023 : 0;
         fare = $urandom_range(1) ? 65535 : 0;
      end else begin
         point = $urandom_range(1023);
         fare = $urandom_range(65535);
      end
      add_request(op, $urandom_range(255), fare, point);
   endtask

   // request driver
   always @(posedge clock) begin : drive
      fare_request_type nxt;
      int idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         idle_pct = (sent_count < 167) ? 24 : (sent_count < 334) ? 87 : 0;
         if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
            nxt = pending_requests.pop_front();
            sent_count++;
            start <= 1'b1;
            req_operation <= nxt.op;
            req_tag <= nxt.tag;
            req_fare <= nxt.fare;
            req_point <= nxt.point;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // predict on accepted request, check response, watchdog
   always @(posedge clock) begin : watch
      fare_request_type seen;
      queue_response_type got;
      queue_response_type want;
      logic took;
      if (!reset) begin
         took = 1'b0;
         if (start && !busy) begin
            seen.op = req_operation;
            seen.tag = req_tag;
            seen.fare = req_fare;
            seen.point = req_point;
            expected_responses.push_back(predict_response(seen));
            took = 1'b1;
         end
         if (rsp_strobe) begin
            took = 1'b1;
            got.status = rsp_status;
            got.tag = rsp_out_tag;
            got.fare = rsp_out_fare;
            got.point = rsp_out_point;
            got.occupancy = rsp_occupancy;
            if (expected_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_MAX)
                  $display("%0t: unexpected response status %0d tag %0d fare %0d point %0d occ %0d",
                           $time, got.status, got.tag, got.fare, got.point, got.occupancy);
            end else begin
               want = expected_responses.pop_front();
               if (got.status !== want.status || got.tag !== want.tag ||
                   got.fare !== want.fare || got.point !== want.point ||
                   got.occupancy !== want.occupancy) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOWN_MAX)
                     $display({"%0t: mismatch exp status %0d tag %0d fare %0d point %0d occ %0d,",
                               " got status %0d tag %0d fare %0d point %0d occ %0d"},
                              $time, want.status, want.tag, want.fare, want.point,
                              want.occupancy, got.status, got.tag, got.fare, got.point,
                              got.occupancy);
               end
            end
         end
         quiet_cycles = took ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[weighted_key_priority_queue_core] ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int n;
      int seg_left;
      int bias;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_INSERT;
      req_tag = '0;
      req_fare = '0;
      req_point = '0;

      // directed: empty removal, extremes, equal keys, fill, full insert, partial drain
      add_request(OP_REMOVE, 8'h5A, 16'hA5A5, 10'h155);
      add_request(OP_INSERT, 255, 65535, 1023);
      add_request(OP_INSERT, 0, 0, 0);
      add_request(OP_INSERT, 1, 65535, 0);
      add_request(OP_INSERT, 2, 0, 1023);
      add_request(OP_INSERT, 3, 100, 2);
      add_request(OP_INSERT, 4, 200, 0);
      add_request(OP_INSERT, 5, 150, 1);
      for (n = 0; n < CAPACITY - 7; n++)
         add_random_request(OP_INSERT);
      add_request(OP_INSERT, 8'hAA, 16'h5555, 10'h2AA);
      for (n = 0; n < 6; n++)
         add_random_request(OP_REMOVE);

      // random: segments that lean to fill or to drain
      seg_left = 0;
      bias = 50;
      for (n = 0; n < RANDOM_REQ; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(40, 15);
            case ($urandom_range(4))
               0: bias = 90;
               1: bias = 75;
               2: bias = 50;
               3: bias = 25;
               default: bias = 10;
            endcase
         end
         seg_left--;
         add_random_request(($urandom_range(99) < bias) ? OP_INSERT : OP_REMOVE);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || start || expected_responses.size() > 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      if (expected_responses.size() > 0)
         mismatch_count++;

      if (mismatch_count == 0)
         $display("[weighted_key_priority_queue_core] OK");
      else
         $display("[weighted_key_priority_queue_core] ERROR");
      $finish;
   end

endmodule

// File: files.f
src/wkpq_pkg.sv
src/wkpq_cell.sv
src/weighted_key_priority_queue_core.sv
src/wkpq_checker.sv
bench/tb_weighted_key_priority_queue_core.sv
